[sv/qnorm_pkg.sv]
`timescale 1ns / 1ps
// qnorm_pkg: fixed widths, constants and the result word type of the quaternion normalizer
// no dependencies; used by the top level and by its checker

package qnorm_pkg;

    localparam int NCOMP    = 4;                 // components per quaternion
    localparam int OUT_W    = 16;                // width of one result component
    localparam int OUT_FRAC = 14;                // fraction bits of a result component
    localparam int NBITS    = OUT_FRAC + 1;      // result magnitude bits, 0..2^OUT_FRAC
    localparam int R_SHIFT  = 2 * OUT_FRAC + 2;  // scale of the squared target
    localparam int CFG_W    = 21;                // width of min_norm_squared

    localparam logic [OUT_W-1:0] OUT_ONE   = OUT_W'(1 << OUT_FRAC);
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef struct packed {
        logic                     degenerate;
        logic [NCOMP*OUT_W-1:0]   comp;
    } result_t;

endpackage

[sv/quaternion_normalizer.sv]
`timescale 1ns / 1ps
// quaternion_normalizer: scales a quaternion to unit length, Q1.14 results
// depends on qnorm_pkg
//
// path: front stages, start stage, result-bit stages, then the output queue
// one quaternion per cycle while the queue has room; 15 result-bit stages, one bit per stage
// a two-word output queue parts the pipeline from m_tready; the pipeline stops only when full
// reset (aresetn low, synchronous) empties the pipeline and queue, min_norm_squared returns to 1

module quaternion_normalizer #(
    parameter int IN_WIDTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input words
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // fields from bit 0 up: in_x, in_y, in_z, in_w, then zero fill to whole bytes
    input  logic [((qnorm_pkg::NCOMP*IN_WIDTH+7)/8)*8-1:0] s_tdata,
    // result words
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // fields from bit 0 up: out_x, out_y, out_z, out_w
    output logic [qnorm_pkg::NCOMP*qnorm_pkg::OUT_W-1:0] m_tdata,
    // fields from bit 0 up: degenerate
    output logic                                   m_tuser,
    // min_norm_squared write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qnorm_pkg::CFG_W-1:0]            cfg_data
);

    localparam int NCOMP   = qnorm_pkg::NCOMP;
    localparam int NBITS   = qnorm_pkg::NBITS;
    localparam int OUT_W   = qnorm_pkg::OUT_W;
    localparam int CFG_W   = qnorm_pkg::CFG_W;
    localparam int R_SHIFT = qnorm_pkg::R_SHIFT;

    localparam int SQ_W  = 2 * IN_WIDTH - 1;               // one square, up to 2^(2w-2)
    localparam int SUM_W = 2 * IN_WIDTH + 1;               // sum of four squares
    localparam int ACC_W = SUM_W + 2 * NBITS + 2;          // sum times a squared odd trial
    localparam int CMP_W = (SUM_W > CFG_W) ? SUM_W : CFG_W;
    localparam int NSTG  = NBITS + 4;                      // stages ahead of the queue

    // per-component search state: q = s*t^2 for the current odd t = 2n-1,
    // e = increment of q if the next bit of n is set
    typedef struct packed {
        logic [ACC_W-1:0] q;
        logic [ACC_W-1:0] e;
        logic [SQ_W-1:0]  sq;
        logic             neg;
        logic [NBITS-1:0] n;
    } lane_t;

    typedef struct packed {
        lane_t [NCOMP-1:0] lane;
        logic [SUM_W-1:0]  s;
        logic [SUM_W+1:0]  s3;
        logic              degen;
    } item_t;

    // configuration register
    logic [CFG_W-1:0] min_reg;

    // pipeline valid bits, one per stage
    logic [NSTG-1:0] vld_reg;
    logic            pipe_en;

    // front stages: magnitude, square, sum
    logic [IN_WIDTH-1:0] mag1_reg [NCOMP];
    logic [NCOMP-1:0]    neg1_reg;
    logic [SQ_W-1:0]     sq2_reg  [NCOMP];
    logic [NCOMP-1:0]    neg2_reg;
    logic [SQ_W-1:0]     sq3_reg  [NCOMP];
    logic [NCOMP-1:0]    neg3_reg;
    logic [SUM_W-1:0]    sum3_reg;
    logic                degen3_reg;

    // search stages; st_reg[0] holds the starting point
    item_t st_reg [0:NBITS];

    // output queue
    qnorm_pkg::result_t head_reg, head_next;
    qnorm_pkg::result_t tail_reg, tail_next;
    qnorm_pkg::result_t res;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push, pop;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= qnorm_pkg::CFG_RESET;
        end else if (cfg_valid) begin
            min_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // flow control: every stage moves together while the queue has room
    // ---------------------------------------------------------------
    assign pipe_en  = (cnt_reg != 2'd2);
    assign s_tready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------
    // front stages
    // ---------------------------------------------------------------
    logic [IN_WIDTH-1:0]   comp_in  [NCOMP];
    logic [IN_WIDTH-1:0]   mag_next [NCOMP];
    logic [2*IN_WIDTH-1:0] prod     [NCOMP];
    logic [SUM_W-1:0]      sum_next;
    logic                  degen_next;

    always_comb begin
        for (int l = 0; l < NCOMP; l++) begin
            comp_in[l]  = s_tdata[l*IN_WIDTH +: IN_WIDTH];
            // the most negative code maps to 2^(w-1), which still fits unsigned
            mag_next[l] = comp_in[l][IN_WIDTH-1] ? (~comp_in[l] + 1'b1) : comp_in[l];
            prod[l]     = mag1_reg[l] * mag1_reg[l];
        end
        sum_next = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1])
                 + SUM_W'(sq2_reg[2]) + SUM_W'(sq2_reg[3]);
        // a zero quaternion is always degenerate, even with a zero minimum
        degen_next = (sum_next == '0) || (CMP_W'(sum_next) < CMP_W'(min_reg));
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int l = 0; l < NCOMP; l++) begin
                mag1_reg[l] <= mag_next[l];
                neg1_reg[l] <= comp_in[l][IN_WIDTH-1];
                sq2_reg[l]  <= prod[l][SQ_W-1:0];
                sq3_reg[l]  <= sq2_reg[l];
            end
            neg2_reg   <= neg1_reg;
            neg3_reg   <= neg2_reg;
            sum3_reg   <= sum_next;
            degen3_reg <= degen_next;
        end
    end

    // ---------------------------------------------------------------
    // starting point: n = 0, t = -1, q = s,
    // first increment e = s*(2^(2k+2) - 2^(k+2)) for the top bit k
    // ---------------------------------------------------------------
    item_t init_next;

    always_comb begin
        init_next.s     = sum3_reg;
        init_next.s3    = (SUM_W+2)'(sum3_reg) + ((SUM_W+2)'(sum3_reg) << 1);
        init_next.degen = degen3_reg;
        for (int l = 0; l < NCOMP; l++) begin
            init_next.lane[l].q   = ACC_W'(sum3_reg);
            init_next.lane[l].e   = (ACC_W'(sum3_reg) << R_SHIFT)
                                  - (ACC_W'(sum3_reg) << (NBITS + 1));
            init_next.lane[l].sq  = sq3_reg[l];
            init_next.lane[l].neg = neg3_reg[l];
            init_next.lane[l].n   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            st_reg[0] <= init_next;
        end
    end

    // ---------------------------------------------------------------
    // result-bit stages, top bit first: keep bit k of n if s*(2n-1)^2
    // stays at or below c^2 * 2^30; once n reaches 1.0 it saturates there
    // ---------------------------------------------------------------
    for (genvar j = 1; j <= NBITS; j++) begin : g_bit
        localparam int K = NBITS - j;

        item_t            stage_next;
        logic [ACC_W-1:0] cand [NCOMP];
        logic [ACC_W-1:0] rhs  [NCOMP];
        logic [NCOMP-1:0] keep;

        always_comb begin
            stage_next = st_reg[j-1];
            for (int l = 0; l < NCOMP; l++) begin
                cand[l] = st_reg[j-1].lane[l].q + st_reg[j-1].lane[l].e;
                rhs[l]  = ACC_W'(st_reg[j-1].lane[l].sq) << R_SHIFT;
                keep[l] = (cand[l] <= rhs[l])
                        && ((K == NBITS - 1) || !st_reg[j-1].lane[l].n[NBITS-1]);
                // next increment: e/2 + 3s*4^k when the bit is kept, e/2 - s*4^k otherwise
                if (keep[l]) begin
                    stage_next.lane[l].q    = cand[l];
                    stage_next.lane[l].n[K] = 1'b1;
                    stage_next.lane[l].e    = (st_reg[j-1].lane[l].e >> 1)
                                            + (ACC_W'(st_reg[j-1].s3) << (2 * K));
                end else begin
                    stage_next.lane[l].e    = (st_reg[j-1].lane[l].e >> 1)
                                            - (ACC_W'(st_reg[j-1].s) << (2 * K));
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (pipe_en) begin
                st_reg[j] <= stage_next;
            end
        end
    end

    // ---------------------------------------------------------------
    // sign and identity selection, then the output queue
    // ---------------------------------------------------------------
    logic [OUT_W-1:0] mag_out [NCOMP];

    always_comb begin
        res.degenerate = st_reg[NBITS].degen;
        for (int l = 0; l < NCOMP; l++) begin
            mag_out[l] = OUT_W'(st_reg[NBITS].lane[l].n);
            if (st_reg[NBITS].degen) begin
                res.comp[l*OUT_W +: OUT_W] = (l == NCOMP - 1) ? qnorm_pkg::OUT_ONE : '0;
            end else if (st_reg[NBITS].lane[l].neg) begin
                res.comp[l*OUT_W +: OUT_W] = ~mag_out[l] + 1'b1;
            end else begin
                res.comp[l*OUT_W +: OUT_W] = mag_out[l];
            end
        end
    end

    assign push = pipe_en && vld_reg[NSTG-1];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
        if (pop) begin
            if (cnt_reg == 2'd2) begin
                head_next = tail_reg;
            end else if (push) begin
                head_next = res;
            end
        end else if (push) begin
            if (cnt_reg == 2'd0) begin
                head_next = res;
            end else begin
                tail_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = head_reg.comp;
    assign m_tuser  = head_reg.degenerate;

endmodule

[sv/qnorm_checker.sv]
`timescale 1ns / 1ps
// qnorm_checker: port-level assertions on the result channel of the quaternion normalizer
// depends on qnorm_pkg; bound to quaternion_normalizer at the end of this file

module qnorm_checker (
    input logic                                      aclk,
    input logic                                      aresetn,
    input logic                                      m_tvalid,
    input logic                                      m_tready,
    input logic [qnorm_pkg::NCOMP*qnorm_pkg::OUT_W-1:0] m_tdata,
    input logic                                      m_tuser
);

    localparam int NCOMP = qnorm_pkg::NCOMP;
    localparam int OUT_W = qnorm_pkg::OUT_W;

    localparam logic [NCOMP*OUT_W-1:0] IDENTITY =
        {qnorm_pkg::OUT_ONE, {(NCOMP-1)*OUT_W{1'b0}}};

    logic signed [OUT_W-1:0] comp [NCOMP];
    logic [NCOMP-1:0]        in_range;
    logic [NCOMP-1:0]        big;

    always_comb begin
        for (int l = 0; l < NCOMP; l++) begin
            comp[l]     = $signed(m_tdata[l*OUT_W +: OUT_W]);
            in_range[l] = (comp[l] <= $signed(qnorm_pkg::OUT_ONE))
                       && (comp[l] >= -$signed(qnorm_pkg::OUT_ONE));
            // the largest component of a unit quaternion is at least one half
            big[l]      = (comp[l] >= $signed(qnorm_pkg::OUT_ONE >> 1))
                       || (comp[l] <= -$signed(qnorm_pkg::OUT_ONE >> 1));
        end
    end

    // degenerate words carry the identity quaternion
    a_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == IDENTITY)
        else $error("degenerate word is not the identity");

    // normalized words stay within +-1.0 and are not all small
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (&in_range) && (|big))
        else $error("normalized word is not near unit length");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // reset leaves nothing to deliver
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind quaternion_normalizer qnorm_checker u_qnorm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
